// ===== rtl/qvr_pkg.sv =====
// shared types and constants of the quaternion vector rotator
// no dependencies; imported by the top, qvr_ham1, qvr_ham2 and the testbench
package qvr_pkg;

	localparam int QUAT_WIDTH      = 16;
	localparam int CFG_INDEX_WIDTH = 2;
	localparam int CFG_DATA_WIDTH  = QUAT_WIDTH;

	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_QUAT_SCALAR = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_QUAT_I      = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_QUAT_J      = 2'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_QUAT_K      = 2'd3;

	localparam logic signed [QUAT_WIDTH-1:0] QUAT_SCALAR_RESET = 16'sd16384;
	localparam logic signed [QUAT_WIDTH-1:0] QUAT_IMAG_RESET   = 16'sd0;

	typedef struct packed {
		logic signed [QUAT_WIDTH-1:0] s;
		logic signed [QUAT_WIDTH-1:0] a;
		logic signed [QUAT_WIDTH-1:0] b;
		logic signed [QUAT_WIDTH-1:0] c;
	} quat_t;

	typedef struct packed {
		logic first;
		logic second;
	} stage_en_t;

endpackage

// ===== rtl/qvr_vec_if.sv =====
// valid/ready channel carrying one input vector transaction
// no dependencies
interface qvr_vec_if #(
	parameter int VEC_WIDTH = 16
);
	logic                        valid;
	logic                        ready;
	logic                        mode;
	logic signed [VEC_WIDTH-1:0] vec_x;
	logic signed [VEC_WIDTH-1:0] vec_y;
	logic signed [VEC_WIDTH-1:0] vec_z;

	modport source (output valid, output mode, output vec_x, output vec_y, output vec_z,
		input ready);
	modport sink (input valid, input mode, input vec_x, input vec_y, input vec_z,
		output ready);
endinterface

// ===== rtl/qvr_rot_if.sv =====
// valid/ready channel carrying one rotated vector transaction
// no dependencies
interface qvr_rot_if #(
	parameter int VEC_WIDTH = 16
);
	logic                        valid;
	logic                        ready;
	logic signed [VEC_WIDTH-1:0] rot_x;
	logic signed [VEC_WIDTH-1:0] rot_y;
	logic signed [VEC_WIDTH-1:0] rot_z;
	logic                        saturated;

	modport source (output valid, output rot_x, output rot_y, output rot_z,
		output saturated, input ready);
	modport sink (input valid, input rot_x, input rot_y, input rot_z,
		input saturated, output ready);
endinterface

// ===== rtl/quaternion_vector_rotate.sv =====
// quaternion vector rotator, top level: config registers, stage valids, handshake
// an input transaction passes through the stage registers s1, s2, s3 and s4, and the
// output valid is the s4 valid; one transaction per cycle,
// limited only by the output side: each stage moves on when the next is empty or moving
// reset clears all stage valids and loads the identity quaternion
// depends on qvr_pkg, qvr_vec_if, qvr_rot_if, qvr_ham1, qvr_ham2
module quaternion_vector_rotate import qvr_pkg::*; #(
	parameter int VEC_WIDTH = 16,
	parameter int FRAC_BITS = 14
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
	qvr_vec_if.sink                    vec,
	qvr_rot_if.source                  rot
);

	localparam int TW = QUAT_WIDTH + VEC_WIDTH + 2 - FRAC_BITS;

	quat_t     quat_q;
	logic      v_s1, v_s2, v_s3, v_s4;
	logic      en1, en2, en3, en4;
	stage_en_t en_a, en_b;

	logic              mode_s2;
	logic signed [TW-1:0] ts_s2, tx_s2, ty_s2, tz_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_q.s <= QUAT_SCALAR_RESET;
			quat_q.a <= QUAT_IMAG_RESET;
			quat_q.b <= QUAT_IMAG_RESET;
			quat_q.c <= QUAT_IMAG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_QUAT_SCALAR: quat_q.s <= cfg_data;
				CFG_QUAT_I:      quat_q.a <= cfg_data;
				CFG_QUAT_J:      quat_q.b <= cfg_data;
				CFG_QUAT_K:      quat_q.c <= cfg_data;
				default:         quat_q   <= quat_q;
			endcase
		end
	end

	// a stage loads when it is empty or its content moves on
	assign en4 = !v_s4 || rot.ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	assign en_a = '{first: en1, second: en2};
	assign en_b = '{first: en3, second: en4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= vec.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	assign vec.ready = en1;
	assign rot.valid = v_s4;

	qvr_ham1 #(
		.VEC_WIDTH(VEC_WIDTH),
		.FRAC_BITS(FRAC_BITS)
	) u_ham1 (
		.clk     (clk),
		.en      (en_a),
		.quat    (quat_q),
		.mode    (vec.mode),
		.vec_x   (vec.vec_x),
		.vec_y   (vec.vec_y),
		.vec_z   (vec.vec_z),
		.mode_s2 (mode_s2),
		.ts_s2   (ts_s2),
		.tx_s2   (tx_s2),
		.ty_s2   (ty_s2),
		.tz_s2   (tz_s2)
	);

	qvr_ham2 #(
		.VEC_WIDTH(VEC_WIDTH),
		.FRAC_BITS(FRAC_BITS)
	) u_ham2 (
		.clk      (clk),
		.en       (en_b),
		.quat     (quat_q),
		.mode_s2  (mode_s2),
		.ts_s2    (ts_s2),
		.tx_s2    (tx_s2),
		.ty_s2    (ty_s2),
		.tz_s2    (tz_s2),
		.rot_x_s4 (rot.rot_x),
		.rot_y_s4 (rot.rot_y),
		.rot_z_s4 (rot.rot_z),
		.sat_s4   (rot.saturated)
	);

endmodule

// ===== rtl/qvr_ham1.sv =====
// first hamilton product: stage 1 partial products, stage 2 sums and truncation
// depends on qvr_pkg
module qvr_ham1 import qvr_pkg::*; #(
	parameter int VEC_WIDTH = 16,
	parameter int FRAC_BITS = 14,
	localparam int PW = QUAT_WIDTH + VEC_WIDTH,
	localparam int SW = PW + 2,
	localparam int TW = SW - FRAC_BITS
) (
	input  logic                        clk,
	input  stage_en_t                   en,
	input  quat_t                       quat,
	input  logic                        mode,
	input  logic signed [VEC_WIDTH-1:0] vec_x,
	input  logic signed [VEC_WIDTH-1:0] vec_y,
	input  logic signed [VEC_WIDTH-1:0] vec_z,
	output logic                        mode_s2,
	output logic signed [TW-1:0]        ts_s2,
	output logic signed [TW-1:0]        tx_s2,
	output logic signed [TW-1:0]        ty_s2,
	output logic signed [TW-1:0]        tz_s2
);

	logic              mode_s1;
	logic signed [PW-1:0] p_ax_s1, p_by_s1, p_cz_s1;
	logic signed [PW-1:0] p_sx_s1, p_bz_s1, p_cy_s1;
	logic signed [PW-1:0] p_sy_s1, p_cx_s1, p_az_s1;
	logic signed [PW-1:0] p_sz_s1, p_ay_s1, p_bx_s1;

	logic signed [SW-1:0] dot, neg_dot;
	logic signed [SW-1:0] cross_x, cross_y, cross_z;
	logic signed [SW-1:0] sum_x, sum_y, sum_z;

	always_ff @(posedge clk) begin
		if (en.first) begin
			mode_s1 <= mode;
			p_ax_s1 <= PW'(quat.a) * PW'(vec_x);
			p_by_s1 <= PW'(quat.b) * PW'(vec_y);
			p_cz_s1 <= PW'(quat.c) * PW'(vec_z);
			p_sx_s1 <= PW'(quat.s) * PW'(vec_x);
			p_bz_s1 <= PW'(quat.b) * PW'(vec_z);
			p_cy_s1 <= PW'(quat.c) * PW'(vec_y);
			p_sy_s1 <= PW'(quat.s) * PW'(vec_y);
			p_cx_s1 <= PW'(quat.c) * PW'(vec_x);
			p_az_s1 <= PW'(quat.a) * PW'(vec_z);
			p_sz_s1 <= PW'(quat.s) * PW'(vec_z);
			p_ay_s1 <= PW'(quat.a) * PW'(vec_y);
			p_bx_s1 <= PW'(quat.b) * PW'(vec_x);
		end
	end

	// inverse rotation flips the sign of the cross-product terms
	always_comb begin
		dot     = SW'(p_ax_s1) + SW'(p_by_s1) + SW'(p_cz_s1);
		neg_dot = -dot;
		cross_x = SW'(p_bz_s1) - SW'(p_cy_s1);
		cross_y = SW'(p_cx_s1) - SW'(p_az_s1);
		cross_z = SW'(p_ay_s1) - SW'(p_bx_s1);
		sum_x   = SW'(p_sx_s1) + (mode_s1 ? -cross_x : cross_x);
		sum_y   = SW'(p_sy_s1) + (mode_s1 ? -cross_y : cross_y);
		sum_z   = SW'(p_sz_s1) + (mode_s1 ? -cross_z : cross_z);
	end

	always_ff @(posedge clk) begin
		if (en.second) begin
			mode_s2 <= mode_s1;
			ts_s2   <= neg_dot[SW-1:FRAC_BITS];
			tx_s2   <= sum_x[SW-1:FRAC_BITS];
			ty_s2   <= sum_y[SW-1:FRAC_BITS];
			tz_s2   <= sum_z[SW-1:FRAC_BITS];
		end
	end

endmodule

// ===== rtl/qvr_ham2.sv =====
// second hamilton product: stage 3 partial products, stage 4 sums, truncation
// and saturation into the output register; depends on qvr_pkg
module qvr_ham2 import qvr_pkg::*; #(
	parameter int VEC_WIDTH = 16,
	parameter int FRAC_BITS = 14,
	localparam int TW  = QUAT_WIDTH + VEC_WIDTH + 2 - FRAC_BITS,
	localparam int PW2 = QUAT_WIDTH + TW,
	localparam int SW2 = PW2 + 2,
	localparam int RW  = SW2 - FRAC_BITS
) (
	input  logic                        clk,
	input  stage_en_t                   en,
	input  quat_t                       quat,
	input  logic                        mode_s2,
	input  logic signed [TW-1:0]        ts_s2,
	input  logic signed [TW-1:0]        tx_s2,
	input  logic signed [TW-1:0]        ty_s2,
	input  logic signed [TW-1:0]        tz_s2,
	output logic signed [VEC_WIDTH-1:0] rot_x_s4,
	output logic signed [VEC_WIDTH-1:0] rot_y_s4,
	output logic signed [VEC_WIDTH-1:0] rot_z_s4,
	output logic                        sat_s4
);

	logic                  mode_s3;
	logic signed [PW2-1:0] p_stx_s3, p_sty_s3, p_stz_s3;
	logic signed [PW2-1:0] p_tsa_s3, p_tsb_s3, p_tsc_s3;
	logic signed [PW2-1:0] p_tzb_s3, p_tyc_s3, p_txc_s3;
	logic signed [PW2-1:0] p_tza_s3, p_tya_s3, p_txb_s3;

	logic signed [SW2-1:0] cross_x, cross_y, cross_z;
	logic signed [SW2-1:0] sum_x, sum_y, sum_z;
	logic signed [RW-1:0]  r [3];
	logic signed [VEC_WIDTH-1:0] clip [3];
	logic [2:0] sat;

	always_ff @(posedge clk) begin
		if (en.first) begin
			mode_s3  <= mode_s2;
			p_stx_s3 <= PW2'(quat.s) * PW2'(tx_s2);
			p_sty_s3 <= PW2'(quat.s) * PW2'(ty_s2);
			p_stz_s3 <= PW2'(quat.s) * PW2'(tz_s2);
			p_tsa_s3 <= PW2'(quat.a) * PW2'(ts_s2);
			p_tsb_s3 <= PW2'(quat.b) * PW2'(ts_s2);
			p_tsc_s3 <= PW2'(quat.c) * PW2'(ts_s2);
			p_tzb_s3 <= PW2'(quat.b) * PW2'(tz_s2);
			p_tyc_s3 <= PW2'(quat.c) * PW2'(ty_s2);
			p_txc_s3 <= PW2'(quat.c) * PW2'(tx_s2);
			p_tza_s3 <= PW2'(quat.a) * PW2'(tz_s2);
			p_tya_s3 <= PW2'(quat.a) * PW2'(ty_s2);
			p_txb_s3 <= PW2'(quat.b) * PW2'(tx_s2);
		end
	end

	always_comb begin
		cross_x = SW2'(p_tzb_s3) - SW2'(p_tyc_s3);
		cross_y = SW2'(p_txc_s3) - SW2'(p_tza_s3);
		cross_z = SW2'(p_tya_s3) - SW2'(p_txb_s3);
		sum_x   = SW2'(p_stx_s3) - SW2'(p_tsa_s3) + (mode_s3 ? -cross_x : cross_x);
		sum_y   = SW2'(p_sty_s3) - SW2'(p_tsb_s3) + (mode_s3 ? -cross_y : cross_y);
		sum_z   = SW2'(p_stz_s3) - SW2'(p_tsc_s3) + (mode_s3 ? -cross_z : cross_z);
		r[0]    = sum_x[SW2-1:FRAC_BITS];
		r[1]    = sum_y[SW2-1:FRAC_BITS];
		r[2]    = sum_z[SW2-1:FRAC_BITS];
	end

	for (genvar i = 0; i < 3; i++) begin : g_lim
		if (RW > VEC_WIDTH) begin : g_clip
			logic [RW-VEC_WIDTH:0] upper;
			assign upper = r[i][RW-1:VEC_WIDTH-1];
			always_comb begin
				if ((&upper) || !(|upper)) begin
					sat[i]  = 1'b0;
					clip[i] = r[i][VEC_WIDTH-1:0];
				end else if (r[i][RW-1]) begin
					sat[i]  = 1'b1;
					clip[i] = {1'b1, {(VEC_WIDTH-1){1'b0}}};
				end else begin
					sat[i]  = 1'b1;
					clip[i] = {1'b0, {(VEC_WIDTH-1){1'b1}}};
				end
			end
		end else begin : g_ext
			assign sat[i]  = 1'b0;
			assign clip[i] = VEC_WIDTH'(r[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en.second) begin
			rot_x_s4 <= clip[0];
			rot_y_s4 <= clip[1];
			rot_z_s4 <= clip[2];
			sat_s4   <= |sat;
		end
	end

endmodule

// ===== rtl/qvr_checker.sv =====
// port-level checks of the quaternion vector rotator, bound to the top level
// depends on quaternion_vector_rotate
module qvr_checker #(
	parameter int VEC_WIDTH = 16
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        vec_valid,
	input logic                        vec_ready,
	input logic                        rot_valid,
	input logic                        rot_ready,
	input logic signed [VEC_WIDTH-1:0] rot_x,
	input logic signed [VEC_WIDTH-1:0] rot_y,
	input logic signed [VEC_WIDTH-1:0] rot_z,
	input logic                        rot_saturated
);

	localparam logic signed [VEC_WIDTH-1:0] SAT_MAX = {1'b0, {(VEC_WIDTH-1){1'b1}}};
	localparam logic signed [VEC_WIDTH-1:0] SAT_MIN = {1'b1, {(VEC_WIDTH-1){1'b0}}};

	// stalled output transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rot_valid && !rot_ready |=> rot_valid && $stable(rot_x) && $stable(rot_y)
			&& $stable(rot_z) && $stable(rot_saturated))
		else $error("output transaction changed while stalled");

	// empty output register means the pipeline takes input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rot_valid |-> vec_ready)
		else $error("input stalled with empty output register");

	// accepted transaction shows at the output while the output side is ready
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(vec_valid && vec_ready) ##1 rot_ready ##1 rot_ready ##1 rot_ready |=> rot_valid)
		else $error("transaction missing after pipeline latency");

	// saturation flag implies a clipped component
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		rot_valid && rot_saturated |-> rot_x == SAT_MAX || rot_x == SAT_MIN
			|| rot_y == SAT_MAX || rot_y == SAT_MIN
			|| rot_z == SAT_MAX || rot_z == SAT_MIN)
		else $error("saturation flagged without a clipped component");

endmodule

bind quaternion_vector_rotate qvr_checker #(
	.VEC_WIDTH(VEC_WIDTH)
) u_qvr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.vec_valid     (vec.valid),
	.vec_ready     (vec.ready),
	.rot_valid     (rot.valid),
	.rot_ready     (rot.ready),
	.rot_x         (rot.rot_x),
	.rot_y         (rot.rot_y),
	.rot_z         (rot.rot_z),
	.rot_saturated (rot.saturated)
);

// ===== dv/quaternion_vector_rotate_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench for quaternion_vector_rotate: directed and random vector transactions
// over several quaternion settings, checked against an in-bench rotation predictor
// depends on qvr_pkg, qvr_vec_if, qvr_rot_if and the rtl of the rotator
module quaternion_vector_rotate_test;
	import qvr_pkg::*;

	localparam int VW   = 16;
	localparam int FRAC = 14;

	localparam logic MODE_FORWARD = 1'b0;
	localparam logic MODE_INVERSE = 1'b1;

	localparam logic signed [VW-1:0] V_MAX = 16'sh7fff;
	localparam logic signed [VW-1:0] V_MIN = 16'sh8000;
	localparam logic signed [QUAT_WIDTH-1:0] Q_MAX  = 16'sh7fff;
	localparam logic signed [QUAT_WIDTH-1:0] Q_MIN  = 16'sh8000;
	localparam logic signed [QUAT_WIDTH-1:0] Q_HALF = 16'sd11585;

	typedef struct packed {
		logic signed [VW-1:0] x;
		logic signed [VW-1:0] y;
		logic signed [VW-1:0] z;
		logic                 sat;
	} rot_vec_t;

	class rotation_scoreboard;
		logic signed [QUAT_WIDTH-1:0] quat_reg [4];
		rot_vec_t expected_q [$];
		int unsigned mismatches;

		function new();
			quat_reg[CFG_QUAT_SCALAR] = QUAT_SCALAR_RESET;
			quat_reg[CFG_QUAT_I]      = QUAT_IMAG_RESET;
			quat_reg[CFG_QUAT_J]      = QUAT_IMAG_RESET;
			quat_reg[CFG_QUAT_K]      = QUAT_IMAG_RESET;
			mismatches = 0;
		endfunction

		function void set_reg(logic [CFG_INDEX_WIDTH-1:0] index, logic [CFG_DATA_WIDTH-1:0] data);
			quat_reg[index] = data;
		endfunction

		function longint clamp(longint v, inout bit hit);
			longint hi;
			longint lo;
			hi = (longint'(1) <<< (VW - 1)) - 1;
			lo = -hi - 1;
			if (v > hi) begin
				hit = 1'b1;
				return hi;
			end
			if (v < lo) begin
				hit = 1'b1;
				return lo;
			end
			return v;
		endfunction

		function rot_vec_t rotate(logic m, logic signed [VW-1:0] x_in, logic signed [VW-1:0] y_in,
			logic signed [VW-1:0] z_in);
			longint s, a, b, c, vx, vy, vz;
			longint ts, tx, ty, tz, rx, ry, rz;
			bit hit;
			rot_vec_t r;
			s  = longint'(quat_reg[CFG_QUAT_SCALAR]);
			a  = longint'(quat_reg[CFG_QUAT_I]);
			b  = longint'(quat_reg[CFG_QUAT_J]);
			c  = longint'(quat_reg[CFG_QUAT_K]);
			vx = longint'(x_in);
			vy = longint'(y_in);
			vz = longint'(z_in);
			hit = 1'b0;
			if (m == MODE_FORWARD) begin
				// q * (0, v), then * conj(q)
				ts = (-(a * vx + b * vy + c * vz)) >>> FRAC;
				tx = (s * vx + b * vz - c * vy) >>> FRAC;
				ty = (s * vy + c * vx - a * vz) >>> FRAC;
				tz = (s * vz + a * vy - b * vx) >>> FRAC;
				rx = (s * tx - ts * a - ty * c + tz * b) >>> FRAC;
				ry = (s * ty - ts * b - tz * a + tx * c) >>> FRAC;
				rz = (s * tz - ts * c - tx * b + ty * a) >>> FRAC;
			end else begin
				// (0, v) * q, then conj(q) * that
				ts = (-(vx * a + vy * b + vz * c)) >>> FRAC;
				tx = (s * vx + vy * c - vz * b) >>> FRAC;
				ty = (s * vy + vz * a - vx * c) >>> FRAC;
				tz = (s * vz + vx * b - vy * a) >>> FRAC;
				rx = (s * tx - ts * a - b * tz + c * ty) >>> FRAC;
				ry = (s * ty - ts * b - c * tx + a * tz) >>> FRAC;
				rz = (s * tz - ts * c - a * ty + b * tx) >>> FRAC;
			end
			r.x   = VW'(clamp(rx, hit));
			r.y   = VW'(clamp(ry, hit));
			r.z   = VW'(clamp(rz, hit));
			r.sat = hit;
			return r;
		endfunction

		function void note_input(logic m, logic signed [VW-1:0] x, logic signed [VW-1:0] y,
			logic signed [VW-1:0] z);
			expected_q.push_back(rotate(m, x, y, z));
		endfunction

		function void check_result(logic signed [VW-1:0] x, logic signed [VW-1:0] y,
			logic signed [VW-1:0] z, logic sat);
			rot_vec_t e;
			if (expected_q.size() == 0) begin
				$display("%0t unexpected rotated vector: expected none, got %0d %0d %0d sat %0b",
					$time, x, y, z, sat);
				mismatches++;
				return;
			end
			e = expected_q.pop_front();
			if (x !== e.x) begin
				$display("%0t rot_x mismatch: expected %0d, got %0d", $time, e.x, x);
				mismatches++;
			end
			if (y !== e.y) begin
				$display("%0t rot_y mismatch: expected %0d, got %0d", $time, e.y, y);
				mismatches++;
			end
			if (z !== e.z) begin
				$display("%0t rot_z mismatch: expected %0d, got %0d", $time, e.z, z);
				mismatches++;
			end
			if (sat !== e.sat) begin
				$display("%0t saturated mismatch: expected %0b, got %0b", $time, e.sat, sat);
				mismatches++;
			end
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index;
	logic [CFG_DATA_WIDTH-1:0]  cfg_data;

	qvr_vec_if #(.VEC_WIDTH(VW)) vec_ch ();
	qvr_rot_if #(.VEC_WIDTH(VW)) rot_ch ();

	rotation_scoreboard sb;
	bit                 idle_on;
	int unsigned        results_seen;

	quaternion_vector_rotate #(
		.VEC_WIDTH(VW),
		.FRAC_BITS(FRAC)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.vec      (vec_ch.sink),
		.rot      (rot_ch.source)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	// sink side: random stalls per transaction plus two long hold-offs
	initial begin
		int stall_left;
		int hold_left;
		logic rdy_next;
		stall_left = 0;
		hold_left = 0;
		results_seen = 0;
		rot_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rot_ch.valid === 1'b1 && rot_ch.ready === 1'b1) begin
				sb.check_result(rot_ch.rot_x, rot_ch.rot_y, rot_ch.rot_z, rot_ch.saturated);
				results_seen++;
				stall_left = idle_on ? $urandom_range(0, 5) : 0;
				if (results_seen == 150 || results_seen == 450)
					hold_left = 80;
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy_next = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rdy_next = 1'b0;
			end else begin
				rdy_next = arst_n;
			end
			rot_ch.ready <= rdy_next;
		end
	end

	task automatic send_vec(logic m, logic signed [VW-1:0] x, logic signed [VW-1:0] y,
		logic signed [VW-1:0] z);
		int gap;
		gap = idle_on ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			vec_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		vec_ch.valid <= 1'b1;
		vec_ch.mode  <= m;
		vec_ch.vec_x <= x;
		vec_ch.vec_y <= y;
		vec_ch.vec_z <= z;
		do @(posedge clk); while (!(vec_ch.valid === 1'b1 && vec_ch.ready === 1'b1));
		sb.note_input(m, x, y, z);
	endtask

	// drain the pipe, then write all four quaternion registers
	task automatic load_quat(logic signed [QUAT_WIDTH-1:0] s, logic signed [QUAT_WIDTH-1:0] a,
		logic signed [QUAT_WIDTH-1:0] b, logic signed [QUAT_WIDTH-1:0] c);
		logic [CFG_INDEX_WIDTH-1:0] idx [4];
		logic [CFG_DATA_WIDTH-1:0]  vals [4];
		idx  = '{CFG_QUAT_SCALAR, CFG_QUAT_I, CFG_QUAT_J, CFG_QUAT_K};
		vals = '{s, a, b, c};
		vec_ch.valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		for (int n = 0; n < 4; n++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[n];
			cfg_data  <= vals[n];
			sb.set_reg(idx[n], vals[n]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [VW-1:0] pick_component();
		case ($urandom_range(0, 9))
			0: return V_MAX;
			1: return V_MIN;
			2, 3: return VW'($urandom_range(0, 255)) - VW'(128);
			default: return VW'($urandom());
		endcase
	endfunction

	function automatic logic signed [QUAT_WIDTH-1:0] pick_quat_part(int kind);
		logic signed [QUAT_WIDTH-1:0] corners [5];
		corners = '{Q_MAX, Q_MIN, QUAT_IMAG_RESET, QUAT_SCALAR_RESET, -QUAT_SCALAR_RESET};
		case (kind)
			0: return QUAT_WIDTH'($urandom());
			1: return QUAT_WIDTH'($urandom_range(0, 2 * 11585)) - Q_HALF;
			default: return corners[$urandom_range(0, 4)];
		endcase
	endfunction

	initial begin
		int kind;
		sb = new();
		idle_on = 1'b1;
		arst_n       <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_index    <= CFG_QUAT_SCALAR;
		cfg_data     <= '0;
		vec_ch.valid <= 1'b0;
		vec_ch.mode  <= MODE_FORWARD;
		vec_ch.vec_x <= '0;
		vec_ch.vec_y <= '0;
		vec_ch.vec_z <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity quaternion straight out of reset
		send_vec(MODE_FORWARD, 0, 0, 0);
		send_vec(MODE_FORWARD, V_MAX, V_MIN, 1);
		send_vec(MODE_INVERSE, V_MIN, V_MAX, -1);
		send_vec(MODE_INVERSE, V_MAX, V_MAX, V_MAX);
		send_vec(MODE_FORWARD, V_MIN, V_MIN, V_MIN);

		// zero quaternion gives a zero vector
		load_quat(0, 0, 0, 0);
		send_vec(MODE_FORWARD, V_MAX, V_MIN, 12345);
		send_vec(MODE_INVERSE, V_MIN, V_MIN, V_MIN);

		load_quat(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
		send_vec(MODE_FORWARD, V_MAX, V_MAX, V_MAX);
		send_vec(MODE_INVERSE, V_MIN, V_MAX, V_MIN);
		send_vec(MODE_FORWARD, 1, -1, 0);

		load_quat(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
		send_vec(MODE_FORWARD, V_MAX, V_MIN, V_MAX);
		send_vec(MODE_INVERSE, V_MIN, V_MIN, V_MIN);
		send_vec(MODE_FORWARD, -1, -1, -1);

		// quarter turn about z
		load_quat(Q_HALF, 0, 0, Q_HALF);
		send_vec(MODE_FORWARD, 1000, 0, 0);
		send_vec(MODE_INVERSE, 1000, 0, 0);
		send_vec(MODE_FORWARD, 0, 1000, -1000);

		load_quat(Q_MAX, Q_MIN, Q_MAX, Q_MIN);
		send_vec(MODE_FORWARD, V_MIN, V_MAX, V_MIN);
		send_vec(MODE_INVERSE, V_MAX, V_MIN, V_MAX);

		for (int p = 0; p < 8; p++) begin
			kind = p % 3;
			load_quat(pick_quat_part(kind), pick_quat_part(kind), pick_quat_part(kind),
				pick_quat_part(kind));
			idle_on = (p != 3 && p != 6);
			for (int n = 0; n < 80; n++)
				send_vec(logic'($urandom_range(0, 1)), pick_component(), pick_component(),
					pick_component());
		end

		vec_ch.valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
